// ----- hw/rtl/bmprp_pkg.sv -----
// shared types and constants of the bmp row pixel packer
package bmprp_pkg;

  // depth_mode codes
  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_4BPP  = 3'd1;
  localparam logic [2:0] DEPTH_8BPP  = 3'd2;
  localparam logic [2:0] DEPTH_16BPP = 3'd3;
  localparam logic [2:0] DEPTH_24BPP = 3'd4;
  localparam logic [2:0] DEPTH_32BPP = 3'd5;

  // configuration register indexes
  localparam logic REG_DEPTH_MODE    = 1'b0;
  localparam logic REG_SWAP_RED_BLUE = 1'b1;

  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0f;

  // one queued job: data bytes, then zero padding
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n_data;
    logic [1:0]      n_pad;
    logic            row_end;
  } bmprp_job_t;

endpackage

// ----- hw/rtl/bmprp_front.sv -----
// front end: config registers, bit/nibble packing and row padding count
module bmprp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic [2:0]            cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [31:0]           pixel_bytes,
  input  logic                  row_end,
  output logic                  push,
  output bmprp_pkg::bmprp_job_t job
);
  import bmprp_pkg::*;

  logic [2:0] depth_r;
  logic       swap_r;
  logic [7:0] acc_r, acc_nxt;
  logic [2:0] held_r, held_nxt;
  logic [1:0] phase_r, phase_nxt;

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] acc_a;
  logic [2:0] held_a;
  logic [2:0] nd;
  logic [1:0] phase_a;
  logic [3:0] shamt;

  assign b0 = pixel_bytes[7:0];
  assign b1 = pixel_bytes[15:8];
  assign b2 = pixel_bytes[23:16];
  assign b3 = pixel_bytes[31:24];

  always_comb begin
    job       = '0;
    job.row_end = row_end;
    acc_a     = acc_r;
    held_a    = held_r;
    nd        = 3'd0;
    case (depth_r)
      DEPTH_1BPP: begin
        acc_a = {acc_r[6:0], (b0 != 8'd0)};
        if (held_r == 3'd7) begin
          job.bytes[0] = acc_a;
          nd     = 3'd1;
          acc_a  = 8'd0;
          held_a = 3'd0;
        end else begin
          held_a = held_r + 3'd1;
        end
      end
      DEPTH_4BPP: begin
        if (held_r != 3'd0) begin
          job.bytes[0] = {b0[3:0], acc_r[3:0]};
          nd     = 3'd1;
          acc_a  = 8'd0;
          held_a = 3'd0;
        end else begin
          acc_a  = b0 & NIBBLE_MASK;
          held_a = 3'd4;
        end
      end
      DEPTH_16BPP: begin
        job.bytes[0] = b0;
        job.bytes[1] = b1;
        nd = 3'd2;
      end
      DEPTH_24BPP: begin
        job.bytes[0] = swap_r ? b2 : b0;
        job.bytes[1] = b1;
        job.bytes[2] = swap_r ? b0 : b2;
        nd = 3'd3;
      end
      DEPTH_32BPP: begin
        job.bytes[0] = swap_r ? b2 : b0;
        job.bytes[1] = b1;
        job.bytes[2] = swap_r ? b0 : b2;
        job.bytes[3] = b3;
        nd = 3'd4;
      end
      default: begin
        job.bytes[0] = b0;
        nd = 3'd1;
      end
    endcase

    // pending bits exist only when no byte went out, so a flush lands in byte 0
    shamt = 4'd8 - {1'b0, held_a};
    if (row_end && held_a != 3'd0) begin
      job.bytes[0] = (depth_r == DEPTH_1BPP) ? 8'(acc_a << shamt) : (acc_a & NIBBLE_MASK);
      nd = 3'd1;
    end

    phase_a = phase_r + nd[1:0];
    job.n_data = nd;
    job.n_pad  = row_end ? 2'(-phase_a) : 2'd0;

    acc_nxt   = row_end ? 8'd0 : acc_a;
    held_nxt  = row_end ? 3'd0 : held_a;
    phase_nxt = row_end ? 2'd0 : phase_a;
  end

  assign push = in_valid && in_ready && (nd != 3'd0 || job.n_pad != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_8BPP;
      swap_r  <= 1'b0;
      acc_r   <= 8'd0;
      held_r  <= 3'd0;
      phase_r <= 2'd0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEPTH_MODE) begin
        depth_r <= cfg_data;
        acc_r   <= 8'd0;
        held_r  <= 3'd0;
      end else begin
        swap_r <= cfg_data[0];
      end
    end else if (in_valid && in_ready) begin
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ----- hw/rtl/bmprp_queue.sv -----
// two-entry job queue between front and back
module bmprp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bmprp_pkg::bmprp_job_t push_job,
  output logic                  not_full,
  input  logic                  pop,
  output logic                  not_empty,
  output bmprp_pkg::bmprp_job_t head
);
  import bmprp_pkg::*;

  bmprp_job_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/bmprp_back.sv -----
// back end: serializes queued jobs into bytes through an output register
module bmprp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  bmprp_pkg::bmprp_job_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  row_done,
  output logic                  run_last
);
  import bmprp_pkg::*;

  bmprp_job_t cur_r;
  logic       cur_valid_r;
  logic [2:0] idx_r;
  logic [2:0] total;
  logic       slot_free, adv, at_end;
  logic       out_valid_r, row_done_r, run_last_r;
  logic [7:0] out_byte_r;

  assign total     = cur_r.n_data + {1'b0, cur_r.n_pad};
  assign slot_free = !out_valid_r || out_ready;
  assign adv       = cur_valid_r && slot_free;
  assign at_end    = (idx_r == total - 3'd1);
  assign q_pop     = q_not_empty && (!cur_valid_r || (adv && at_end));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= (idx_r < cur_r.n_data) ? cur_r.bytes[idx_r[1:0]] : 8'd0;
      run_last_r <= at_end;
      row_done_r <= at_end && cur_r.row_end;
    end
    if (q_pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (adv) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= 3'd0;
      end else if (adv) begin
        if (at_end) cur_valid_r <= 1'b0;
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign row_done  = row_done_r;
  assign run_last  = run_last_r;

endmodule

// ----- hw/rtl/bmp_row_pixel_packer.sv -----
// top level of the bmp row pixel packer
//
//  channel  direction  payload
//  in_*     sink       tdata = pixel_bytes[31:0], tlast = row_end
//  out_*    source     tdata = out_byte[7:0], tlast = row_done, tuser = run_last
//  cfg_*    sink       cfg_index = register, cfg_data = value (0 depth_mode, 1 swap_red_blue)
//
// one pixel is taken per cycle while the two-entry job queue has room
// the back end sends one byte per cycle while out_tready does not stall it; a
// pixel yields 0 to 7 output bytes: data bytes (up to 4) plus row padding (up to 3)
// results pass through a registered output stage; either side may stall freely
// reset is synchronous and active low; cfg writes are always taken
module bmp_row_pixel_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_bytes[31:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,
  output logic        out_tuser,  // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [bmprp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmprp_pkg::*;

  bmprp_job_t push_job, head;
  logic       push, not_full, not_empty, pop;

  assign in_tready = not_full;
  assign cfg_ready = 1'b1;

  bmprp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pixel_bytes (in_tdata),
    .row_end     (in_tlast),
    .push        (push),
    .job         (push_job)
  );

  bmprp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  bmprp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .row_done    (out_tlast),
    .run_last    (out_tuser)
  );

endmodule
